// ===== hdl/bdq_pkg.sv =====
`timescale 1ns / 1ps

package bdq_pkg;

  localparam int DEPTH_DEFAULT       = 64;
  localparam int VALUE_WIDTH_DEFAULT = 32;

  localparam int OP_WIDTH     = 3;
  localparam int VALUE_IN_W   = 32;
  localparam int STATUS_WIDTH = 2;
  localparam int COUNT_WIDTH  = 7;

  localparam logic [OP_WIDTH-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_WIDTH-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_WIDTH-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_WIDTH-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_WIDTH-1:0] OP_SEARCH     = 3'd4;

  localparam logic [STATUS_WIDTH-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_WIDTH-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_WIDTH-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic accept;
    logic exec;
    logic scan;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
  } stat_t;

endpackage

// ===== hdl/bdq_ctrl.sv =====
`timescale 1ns / 1ps

module bdq_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [bdq_pkg::OP_WIDTH-1:0]   operation,
  output logic                           busy,
  output bdq_pkg::cmd_t                  cmd,
  input  bdq_pkg::stat_t                 stat
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd.accept = start && (state == S_IDLE);
    cmd.exec   = (state == S_EXEC);
    cmd.scan   = (state == S_SCAN);
    cmd.finish = (state == S_SCAN) && stat.scan_done;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = (operation == bdq_pkg::OP_SEARCH) ? S_SCAN : S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_IDLE;
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hdl/bdq_dpath.sv =====
`timescale 1ns / 1ps

module bdq_dpath #(
  parameter int DEPTH       = bdq_pkg::DEPTH_DEFAULT,
  parameter int VALUE_WIDTH = bdq_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  bdq_pkg::cmd_t                        cmd,
  output bdq_pkg::stat_t                       stat,
  input  logic [bdq_pkg::OP_WIDTH-1:0]         operation,
  input  logic signed [bdq_pkg::VALUE_IN_W-1:0] value,
  output logic [bdq_pkg::STATUS_WIDTH-1:0]     status,
  output logic                                 found,
  output logic [bdq_pkg::COUNT_WIDTH-1:0]      count,
  output logic                                 done
);

  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int SW     = CW + 1;
  localparam int CountW = bdq_pkg::COUNT_WIDTH;

  logic [bdq_pkg::OP_WIDTH-1:0]     op_q;
  logic [VALUE_WIDTH-1:0]           val_q;
  logic [AW-1:0]                    front;
  logic [CW-1:0]                    cnt;
  logic [AW-1:0]                    scan_ptr;
  logic [CW-1:0]                    scan_left;
  logic                             rvalid;
  logic [VALUE_WIDTH-1:0]           rdata;
  logic [VALUE_WIDTH-1:0]           mem [DEPTH];

  logic                             full;
  logic                             empty;
  logic [AW-1:0]                    front_inc;
  logic [AW-1:0]                    front_dec;
  logic [SW-1:0]                    back_sum;
  logic [AW-1:0]                    back_slot;
  logic [AW-1:0]                    front_next;
  logic [CW-1:0]                    cnt_next;
  logic                             we;
  logic [AW-1:0]                    waddr;
  logic [bdq_pkg::STATUS_WIDTH-1:0] st;
  logic                             rd_en;
  logic                             match;

  assign full      = (cnt == CW'(DEPTH));
  assign empty     = (cnt == '0);
  assign front_inc = (front == AW'(DEPTH - 1)) ? '0 : front + AW'(1);
  assign front_dec = (front == '0) ? AW'(DEPTH - 1) : front - AW'(1);
  assign back_sum  = SW'(front) + SW'(cnt);
  assign back_slot = (back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH)) : AW'(back_sum);

  always_comb begin
    front_next = front;
    cnt_next   = cnt;
    we         = 1'b0;
    waddr      = back_slot;
    st         = bdq_pkg::ST_OK;
    case (op_q)
      bdq_pkg::OP_PUSH_FRONT: begin
        if (full) begin
          st = bdq_pkg::ST_FULL;
        end else begin
          front_next = front_dec;
          waddr      = front_dec;
          we         = 1'b1;
          cnt_next   = cnt + CW'(1);
        end
      end
      bdq_pkg::OP_PUSH_BACK: begin
        if (full) begin
          st = bdq_pkg::ST_FULL;
        end else begin
          we       = 1'b1;
          cnt_next = cnt + CW'(1);
        end
      end
      bdq_pkg::OP_POP_FRONT: begin
        if (empty) begin
          st = bdq_pkg::ST_EMPTY;
        end else begin
          front_next = front_inc;
          cnt_next   = cnt - CW'(1);
        end
      end
      bdq_pkg::OP_POP_BACK: begin
        if (empty) begin
          st = bdq_pkg::ST_EMPTY;
        end else begin
          cnt_next = cnt - CW'(1);
        end
      end
      default: begin
        st = bdq_pkg::ST_OK;
      end
    endcase
  end

  assign rd_en          = cmd.scan && (scan_left != '0);
  assign match          = rvalid && (rdata == val_q);
  assign stat.scan_done = match || ((scan_left == '0) && !rvalid);

  // latch the item
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q  <= operation;
      val_q <= VALUE_WIDTH'(value);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      cnt   <= '0;
    end else if (cmd.exec) begin
      front <= front_next;
      cnt   <= cnt_next;
    end
  end

  // walk the held entries from the front
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_ptr  <= '0;
      scan_left <= '0;
      rvalid    <= 1'b0;
    end else if (cmd.accept) begin
      scan_ptr  <= front;
      scan_left <= cnt;
      rvalid    <= 1'b0;
    end else if (cmd.scan) begin
      rvalid <= rd_en;
      if (rd_en) begin
        scan_ptr  <= (scan_ptr == AW'(DEPTH - 1)) ? '0 : scan_ptr + AW'(1);
        scan_left <= scan_left - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && we) begin
      mem[waddr] <= val_q;
    end
    if (rd_en) begin
      rdata <= mem[scan_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status <= st;
      found  <= 1'b0;
      count  <= CountW'(cnt_next);
    end else if (cmd.finish) begin
      status <= bdq_pkg::ST_OK;
      found  <= match;
      count  <= CountW'(cnt);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.exec || cmd.finish;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(DEPTH))
    else $error("element count above depth");

  a_front_bound: assert property (@(posedge clk) disable iff (rst)
    front <= AW'(DEPTH - 1))
    else $error("front pointer out of range");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for two cycles");

  a_scan_within_count: assert property (@(posedge clk) disable iff (rst)
    cmd.scan |-> (scan_left <= cnt))
    else $error("search walks past held entries");

endmodule

// ===== hdl/bounded_deque_with_search.sv =====
// Double-ended queue of up to DEPTH values with a membership search. An item
// is taken when start is high and busy is low; its result (status, found,
// count) appears with done high for exactly one cycle, in the first cycle in
// which busy is low again, and must be captured then since the receiver cannot
// stall. Pushes, pops and unknown operations pass through the EXEC state alone,
// which updates the queue and registers their result; a new item is taken only
// when busy is low again. A search reads the held entries one per cycle
// through the single read port of the entry memory, front first, and stops
// at the first hit or once every held entry has been compared.
`timescale 1ns / 1ps

module bounded_deque_with_search #(
  parameter int DEPTH       = bdq_pkg::DEPTH_DEFAULT,
  parameter int VALUE_WIDTH = bdq_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [bdq_pkg::OP_WIDTH-1:0]          operation,
  input  logic signed [bdq_pkg::VALUE_IN_W-1:0] value,
  output logic                                  done,
  output logic [bdq_pkg::STATUS_WIDTH-1:0]      status,
  output logic                                  found,
  output logic [bdq_pkg::COUNT_WIDTH-1:0]       count
);

  bdq_pkg::cmd_t  cmd;
  bdq_pkg::stat_t stat;

  bdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .busy      (busy),
    .cmd       (cmd),
    .stat      (stat)
  );

  bdq_dpath #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .operation (operation),
    .value     (value),
    .status    (status),
    .found     (found),
    .count     (count),
    .done      (done)
  );

endmodule
